// File: hdl/gicdf_pkg.sv
`timescale 1ns / 1ps
// gicdf_pkg: shared constants, coefficient tables and rounding helper for the
// Gaussian inverse CDF core. No dependencies.
package gicdf_pkg;

  localparam int PROB_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF = 20;
  localparam int WF            = 28;  // internal fraction bits
  localparam int SIGMA_W       = 24;
  localparam int MEAN_W        = 24;
  localparam int Q_W           = 28;
  localparam int POLY_N        = 9;
  localparam int PW            = 36;  // polynomial accumulator width
  localparam int RW            = 72;  // rounding helper width

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 24'd1048576;
  localparam logic [WF-1:0]      LN2_Q       = 28'd186065280;
  localparam logic signed [30:0] SQRT2_Q     = 31'sd379625062;
  localparam int                 QMAX        = 134217727;
  localparam int                 QMIN        = -134217728;

  typedef logic signed [PW-1:0] poly_t;

  // 1e-12 units to Q28, round to nearest
  function automatic poly_t coef_q(input longint c);
    longint unsigned m;
    m = (c < 0) ? longint'(0) - c : c;
    m = (m * 64'd65536 + 64'd122070312) / 64'd244140625;
    return (c < 0) ? -poly_t'(m) : poly_t'(m);
  endfunction

  // arithmetic right shift, round half away from zero
  function automatic logic signed [RW-1:0] rnd_sh(input logic signed [RW-1:0] v,
                                                 input int k);
    logic signed [RW-1:0] acc;
    acc = v;
    if (k > 0) begin
      acc = v + $signed(RW'(1) << (k - 1));
      if (v < 0) begin
        acc = acc - $signed(RW'(1));
      end
      acc = acc >>> k;
    end
    return acc;
  endfunction

  localparam poly_t MID_Q [POLY_N] = '{
    coef_q(64'sd28102), coef_q(64'sd343274), coef_q(-64'sd3523388),
    coef_q(-64'sd4391507), coef_q(64'sd218580870), coef_q(-64'sd1253725030),
    coef_q(-64'sd4177681640), coef_q(64'sd246640727000), coef_q(64'sd1501409410000)
  };

  localparam poly_t TAIL_Q [POLY_N] = '{
    coef_q(-64'sd200214257), coef_q(64'sd100950558), coef_q(64'sd1349343220),
    coef_q(-64'sd3673428440), coef_q(64'sd5739507730), coef_q(-64'sd7622461300),
    coef_q(64'sd9438870470), coef_q(64'sd1001674060000), coef_q(64'sd2832976820000)
  };

endpackage

// File: hdl/gaussian_inverse_cdf_core.sv
`timescale 1ns / 1ps
// Gaussian inverse CDF core: u -> mean + sigma*sqrt(2)*erfinv(2u-1), fixed point.
// Depends on gicdf_pkg.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  input   | start / busy         | in_prob_code, in_mean_offset
//  result  | out_valid (strobe)   | out_quantile, out_flagged
//  config  | cfg_wr_en            | cfg_wr_data (sigma, Q4.20)
//
// One word per cycle while busy is low, fully pipelined. The pipeline depth is
// dominated by the 28 squaring steps of the log2 unit and the square-root
// steps, one per stage. busy is high only during reset and the cycle after it.
// Reset clears the valid bits and loads sigma with 1.0. The receiver cannot stall.
module gaussian_inverse_cdf_core #(
  parameter int PROB_BITS = gicdf_pkg::PROB_BITS_DEF,
  parameter int FRAC_BITS = gicdf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [PROB_BITS-1:0]                in_prob_code,
  input  logic signed [gicdf_pkg::MEAN_W-1:0] in_mean_offset,
  input  logic                                cfg_wr_en,
  input  logic [gicdf_pkg::SIGMA_W-1:0]       cfg_wr_data,
  output logic                                out_valid,
  output logic signed [gicdf_pkg::Q_W-1:0]    out_quantile,
  output logic                                out_flagged
);
  import gicdf_pkg::*;

  localparam int P     = PROB_BITS;
  localparam int A_W   = 2 * P;
  localparam int E_W   = $clog2(A_W);
  localparam int X_W   = P + 1;
  localparam int M_W   = WF + 1;
  localparam int TC_W  = E_W + WF;
  localparam int W_W   = TC_W;
  localparam int R_W   = (W_W + WF + 1) / 2;
  localparam int V_W   = 2 * R_W;
  localparam int Z_W   = R_W + 2;
  localparam int G_W   = PW + 2;
  localparam int VO_W  = 44;
  localparam int MSH_L = (FRAC_BITS >= 20) ? FRAC_BITS - 20 : 0;
  localparam int MSH_R = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 0;

  localparam int ST_SQ0 = 4;
  localparam int ST_T   = ST_SQ0 + WF;
  localparam int ST_W   = ST_T + 1;
  localparam int ST_RT0 = ST_W + 1;
  localparam int ST_Z   = ST_RT0 + R_W;
  localparam int ST_H0  = ST_Z + 1;
  localparam int ST_EI  = ST_H0 + POLY_N - 1;
  localparam int ST_G   = ST_EI + 1;
  localparam int ST_V   = ST_G + 1;
  localparam int ST_OUT = ST_V + 1;
  localparam int N_ST   = ST_OUT + 1;
  localparam int LATENCY = N_ST;

  localparam logic [TC_W-1:0] CT      = TC_W'(2 * P - 2) << WF;
  localparam logic [W_W-1:0]  FIVE_Q  = W_W'(5) << WF;
  localparam logic [Z_W-1:0]  HALF5_Q = Z_W'(5) << (WF - 1);
  localparam logic [Z_W-1:0]  THREE_Q = Z_W'(3) << WF;
  localparam logic [X_W-1:0]  FULL_X  = X_W'(1) << P;

  typedef struct packed {
    logic                     vld;
    logic                     flag;
    logic signed [MEAN_W-1:0] mean;
    logic signed [X_W-1:0]    xnum;
  } side_t;

  side_t side_r [N_ST];
  side_t side0_nxt;

  logic                busy_r;
  logic [SIGMA_W-1:0]  sigma_r;
  logic [P-1:0]        u_r, u_nxt;
  logic [A_W-1:0]      a_r, a_nxt, a2_r;
  logic [E_W-1:0]      e_r, e_nxt, e3_r;
  logic [M_W-1:0]      m_r, m_nxt;
  logic [P-1:0]        u_comp;
  logic [A_W+WF-1:0]   m_shift;

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      sigma_r <= SIGMA_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr_en) begin
        sigma_r <= cfg_wr_data;
      end
    end
  end

  // front end: clamp, a = u*(2^P-u), leading one, normalize
  always_comb begin
    u_nxt          = (in_prob_code == '0) ? P'(1) : in_prob_code;
    side0_nxt.vld  = start && !busy_r;
    side0_nxt.flag = (in_prob_code == '0);
    side0_nxt.mean = in_mean_offset;
    side0_nxt.xnum = $signed({u_nxt, 1'b0} - FULL_X);
    u_comp         = P'(0) - u_r;
    a_nxt          = {{P{1'b0}}, u_r} * {{P{1'b0}}, u_comp};
    e_nxt          = '0;
    for (int i = 0; i < A_W; i++) begin
      if (a_r[i]) begin
        e_nxt = E_W'(i);
      end
    end
    m_shift = {a2_r, {WF{1'b0}}} >> e_r;
    m_nxt   = m_shift[M_W-1:0];
  end

  always_ff @(posedge clk) begin
    u_r  <= u_nxt;
    a_r  <= a_nxt;
    a2_r <= a_r;
    e_r  <= e_nxt;
    e3_r <= e_r;
    m_r  <= m_nxt;
  end

  // valid and sideband chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_ST; i++) begin
        side_r[i].vld <= 1'b0;
      end
    end else begin
      side_r[0] <= side0_nxt;
      for (int i = 1; i < N_ST; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // log2 fraction: one squaring per stage
  logic [M_W-1:0] sq_m_r [WF];
  logic [E_W-1:0] sq_e_r [WF];
  logic [WF-1:0]  sq_f_r [WF];

  for (genvar j = 0; j < WF; j++) begin : g_sq
    localparam int JP = (j == 0) ? 0 : j - 1;
    logic [M_W-1:0]   m_in, m_o_nxt;
    logic [E_W-1:0]   e_in;
    logic [WF-1:0]    f_in, f_o_nxt;
    logic [2*M_W-1:0] prod;
    logic [M_W:0]     sq;
    always_comb begin
      if (j == 0) begin
        m_in = m_r;
        e_in = e3_r;
        f_in = '0;
      end else begin
        m_in = sq_m_r[JP];
        e_in = sq_e_r[JP];
        f_in = sq_f_r[JP];
      end
      prod = (2*M_W)'(m_in) * (2*M_W)'(m_in);
      sq   = prod[2*M_W-1:WF];
      if (sq[M_W]) begin
        m_o_nxt = sq[M_W:1];
        f_o_nxt = {f_in[WF-2:0], 1'b1};
      end else begin
        m_o_nxt = sq[M_W-1:0];
        f_o_nxt = {f_in[WF-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      sq_m_r[j] <= m_o_nxt;
      sq_e_r[j] <= e_in;
      sq_f_r[j] <= f_o_nxt;
    end
  end

  // t = (2P-2) - log2(a), clamped; w = ln2 * t
  logic [TC_W-1:0]      tc_r, tc_nxt;
  logic signed [TC_W:0] t_s;
  logic [W_W-1:0]       w_r, w_nxt;
  logic [TC_W+WF-1:0]   w_prod;

  always_comb begin
    t_s    = $signed({1'b0, CT}) - $signed({1'b0, sq_e_r[WF-1], sq_f_r[WF-1]});
    tc_nxt = (t_s < 0) ? '0 : t_s[TC_W-1:0];
    w_prod = (TC_W+WF)'(tc_r) * (TC_W+WF)'(LN2_Q) + ((TC_W+WF)'(1) << (WF - 1));
    w_nxt  = w_prod[TC_W+WF-1:WF];
  end

  always_ff @(posedge clk) begin
    tc_r <= tc_nxt;
    w_r  <= w_nxt;
  end

  // integer square root of w<<WF, one result bit per stage
  logic [V_W-1:0] rt_v_r   [R_W];
  logic [V_W-1:0] rt_q_r   [R_W];
  logic           rt_mid_r [R_W];
  logic [Z_W-1:0] rt_zm_r  [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_rt
    localparam logic [V_W-1:0] BIT = V_W'(1) << (2 * (R_W - 1 - k));
    localparam int KP = (k == 0) ? 0 : k - 1;
    logic [V_W-1:0] v_in, q_in, trial, v_o_nxt, q_o_nxt;
    logic           mid_in;
    logic [Z_W-1:0] zm_in;
    always_comb begin
      if (k == 0) begin
        v_in   = V_W'(w_r) << WF;
        q_in   = '0;
        mid_in = (w_r < FIVE_Q);
        zm_in  = Z_W'(w_r) - HALF5_Q;
      end else begin
        v_in   = rt_v_r[KP];
        q_in   = rt_q_r[KP];
        mid_in = rt_mid_r[KP];
        zm_in  = rt_zm_r[KP];
      end
      trial = q_in + BIT;
      if (v_in >= trial) begin
        v_o_nxt = v_in - trial;
        q_o_nxt = (q_in >> 1) + BIT;
      end else begin
        v_o_nxt = v_in;
        q_o_nxt = q_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      rt_v_r[k]   <= v_o_nxt;
      rt_q_r[k]   <= q_o_nxt;
      rt_mid_r[k] <= mid_in;
      rt_zm_r[k]  <= zm_in;
    end
  end

  // branch select
  logic signed [Z_W-1:0] z_r, z_nxt;
  logic                  zmid_r;
  poly_t                 p0_r, p0_nxt;

  always_comb begin
    if (rt_mid_r[R_W-1]) begin
      z_nxt  = $signed(rt_zm_r[R_W-1]);
      p0_nxt = MID_Q[0];
    end else begin
      z_nxt  = $signed(rt_q_r[R_W-1][Z_W-1:0] - THREE_Q);
      p0_nxt = TAIL_Q[0];
    end
  end

  always_ff @(posedge clk) begin
    z_r    <= z_nxt;
    zmid_r <= rt_mid_r[R_W-1];
    p0_r   <= p0_nxt;
  end

  // Horner steps
  poly_t                 hp_r   [POLY_N-1];
  logic signed [Z_W-1:0] hz_r   [POLY_N-1];
  logic                  hmid_r [POLY_N-1];

  for (genvar i = 0; i < POLY_N - 1; i++) begin : g_hn
    localparam int IP = (i == 0) ? 0 : i - 1;
    poly_t                 p_in, c, p_o_nxt;
    logic signed [Z_W-1:0] z_in;
    logic                  mid_in;
    logic signed [RW-1:0]  pz;
    always_comb begin
      if (i == 0) begin
        p_in   = p0_r;
        z_in   = z_r;
        mid_in = zmid_r;
      end else begin
        p_in   = hp_r[IP];
        z_in   = hz_r[IP];
        mid_in = hmid_r[IP];
      end
      c       = mid_in ? MID_Q[i+1] : TAIL_Q[i+1];
      pz      = rnd_sh(RW'(p_in) * RW'(z_in), WF);
      p_o_nxt = c + $signed(pz[PW-1:0]);
    end
    always_ff @(posedge clk) begin
      hp_r[i]   <= p_o_nxt;
      hz_r[i]   <= z_in;
      hmid_r[i] <= mid_in;
    end
  end

  // erfinv = p*x, then sqrt2, then sigma, then mean and saturate
  poly_t                  ei_r, ei_nxt;
  logic signed [G_W-1:0]  g_r, g_nxt;
  logic signed [VO_W-1:0] v_r, v_nxt;
  logic signed [RW-1:0]   ei_full, g_full, v_full, mean_w, mean_rs;
  logic signed [VO_W:0]   sum;
  logic signed [Q_W-1:0]  q_r, q_nxt;
  logic                   flag_r, flag_nxt;

  always_comb begin
    ei_full = rnd_sh(RW'(hp_r[POLY_N-2]) * RW'(side_r[ST_EI-1].xnum), P);
    ei_nxt  = $signed(ei_full[PW-1:0]);
    g_full  = rnd_sh(RW'(ei_r) * RW'(SQRT2_Q), WF);
    g_nxt   = $signed(g_full[G_W-1:0]);
    v_full  = rnd_sh(RW'(g_r) * RW'($signed({1'b0, sigma_r})), WF + 20 - FRAC_BITS);
    v_nxt   = $signed(v_full[VO_W-1:0]);
    mean_w  = RW'(side_r[ST_V].mean);
    mean_rs = rnd_sh(mean_w <<< MSH_L, MSH_R);
    sum     = $signed({v_r[VO_W-1], v_r}) + $signed(mean_rs[VO_W:0]);
    flag_nxt = side_r[ST_V].flag;
    if (sum > $signed((VO_W+1)'(QMAX))) begin
      q_nxt    = $signed(Q_W'(QMAX));
      flag_nxt = 1'b1;
    end else if (sum < $signed((VO_W+1)'(QMIN))) begin
      q_nxt    = $signed(Q_W'(QMIN));
      flag_nxt = 1'b1;
    end else begin
      q_nxt = $signed(sum[Q_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    ei_r   <= ei_nxt;
    g_r    <= g_nxt;
    v_r    <= v_nxt;
    q_r    <= q_nxt;
    flag_r <= flag_nxt;
  end

  assign out_valid    = side_r[ST_OUT].vld;
  assign out_quantile = q_r;
  assign out_flagged  = flag_r;

endmodule

// File: hdl/gicdf_checker.sv
`timescale 1ns / 1ps
// gicdf_checker: port-level assertions for gaussian_inverse_cdf_core, bound to it.
// Depends on the top level's ports and its LATENCY.
module gicdf_checker #(
  parameter int PROB_BITS = 24,
  parameter int LATENCY   = 78
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [PROB_BITS-1:0] in_prob_code,
  input logic                 out_valid,
  input logic                 out_flagged
);

  // every accepted word yields exactly one result
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("accepted word produced no result");

  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching accepted word");

  // zero probability is clamped and always flagged
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_prob_code == '0 |-> ##LATENCY (out_valid && out_flagged))
    else $error("zero probability not flagged");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |=> !busy)
    else $error("busy stuck after reset");

endmodule

bind gaussian_inverse_cdf_core gicdf_checker #(
  .PROB_BITS(PROB_BITS),
  .LATENCY  (LATENCY)
) u_gicdf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_prob_code(in_prob_code),
  .out_valid   (out_valid),
  .out_flagged (out_flagged)
);
